// ----- rtl/lcdt_pkg.sv -----
// Shared types, timing constants and register indexes of the LCD line/mode timing core.
package lcdt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LCD_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_LINE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_IRQ_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OAM_IRQ_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HBLANK_IRQ_EN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_IRQ_EN = 3'd5;

  localparam logic [8:0] DOT_STEP  = 9'd4;
  localparam logic [8:0] OAM_END   = 9'd80;
  localparam logic [8:0] DRAW_END  = 9'd252;
  localparam logic [8:0] LINE_DOTS = 9'd456;

  localparam logic [7:0] VBLANK_FIRST = 8'd144;
  localparam logic [7:0] FRAME_LAST   = 8'd154;
  localparam logic [7:0] RESET_LINE   = 8'd145;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FINISH
  } fsm_t;

  typedef struct packed {
    logic [8:0] dot;
    logic [7:0] line;
    mode_t      mode;
  } lcd_state_t;

  typedef struct packed {
    logic oam;
    logic hblank;
    logic vblank;
  } irq_en_t;

  typedef struct packed {
    logic stat;
    logic vbl;
    logic draw;
    logic frame;
  } step_evt_t;

endpackage

// ----- rtl/lcdt_step_unit.sv -----
// Shared step unit: advances the LCD timing state by one 4-dot step.
module lcdt_step_unit (
  input  lcdt_pkg::lcd_state_t st_i,
  input  lcdt_pkg::irq_en_t    irq_en_i,
  output lcdt_pkg::lcd_state_t st_o,
  output lcdt_pkg::step_evt_t  evt_o
);
  import lcdt_pkg::*;

  logic [8:0] dot_sum;

  // Dot stays below LINE_DOTS between steps, so the sum fits in 9 bits.
  assign dot_sum = st_i.dot + DOT_STEP;

  always_comb begin
    st_o     = st_i;
    st_o.dot = dot_sum;
    evt_o    = '0;
    if (st_i.line < VBLANK_FIRST) begin
      if (dot_sum < OAM_END) begin
        if (st_i.mode != MODE_OAM) begin
          st_o.mode = MODE_OAM;
          evt_o.stat = irq_en_i.oam;
        end
      end else if (dot_sum < DRAW_END) begin
        if (st_i.mode != MODE_DRAW) begin
          st_o.mode = MODE_DRAW;
          evt_o.draw = 1'b1;
        end
      end else if (dot_sum < LINE_DOTS) begin
        if (st_i.mode != MODE_HBLANK) begin
          st_o.mode = MODE_HBLANK;
          evt_o.stat = irq_en_i.hblank;
        end
      end else begin
        st_o.dot  = '0;
        st_o.line = st_i.line + 8'd1;
      end
    end else if (st_i.line < FRAME_LAST) begin
      if (st_i.mode != MODE_VBLANK) begin
        st_o.mode  = MODE_VBLANK;
        evt_o.vbl  = 1'b1;
        evt_o.stat = irq_en_i.vblank;
      end
      if (dot_sum >= LINE_DOTS) begin
        st_o.dot  = dot_sum - LINE_DOTS;
        st_o.line = st_i.line + 8'd1;
      end
    end else begin
      // Last line of the frame: wrap to line 0, mode holds.
      st_o.line   = '0;
      evt_o.frame = 1'b1;
      if (dot_sum >= LINE_DOTS) begin
        st_o.dot = dot_sum - LINE_DOTS;
      end
    end
  end

endmodule

// ----- rtl/lcd_line_mode_timing_core.sv -----
// Top level of the LCD line/mode timing core: config registers, sequencer, result register.
//
// Each input word carries the elapsed CPU time in in_cycles. With the display on,
// the core compares the current line against compare_line and then runs
// ceil(cycles/4) four-dot steps through one shared step unit, one step per clock
// unless a configuration write intervenes. It posts one result word with the
// mode and line after the item, the match flag and the interrupt and event flags
// raised along the way. An item is taken in the idle state, then stepped, and
// the finish state loads the result register; with the display off or a zero
// count no steps run. in_stall is high while the item steps and finishes, and
// the final load also waits while the result register still holds an untaken
// word. Configuration writes land at once and are meant for idle time only;
// turning the display off clears line, dot counter and mode.
module lcd_line_mode_timing_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lcdt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcdt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_cycles,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_mode,
  output logic [7:0]                          out_line,
  output logic                                out_line_match,
  output logic                                out_stat_irq,
  output logic                                out_vblank_irq,
  output logic                                out_draw_line,
  output logic                                out_frame_done
);
  import lcdt_pkg::*;

  // Configuration registers.
  logic       lcd_en_r, lcd_en_nxt;
  logic [7:0] cmp_line_r, cmp_line_nxt;
  logic       match_ie_r, match_ie_nxt;
  irq_en_t    irq_en_r, irq_en_nxt;

  // Timing state and per-item accumulators.
  lcd_state_t st_r, st_nxt;
  logic       match_r, match_nxt;
  step_evt_t  evt_r, evt_nxt;
  logic [6:0] steps_r, steps_nxt;

  // Sequencer.
  fsm_t       state_r, state_nxt;
  logic       in_acc;
  logic       step_en;
  logic       load_out;
  logic       out_free;

  // Step count for the incoming word: ceil(cycles/4), zero when the display is off.
  logic [8:0] cyc_sum;
  logic [6:0] in_steps;

  // Step unit hookup.
  lcd_state_t step_st;
  step_evt_t  step_evt;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  mode_t      out_mode_r;
  logic [7:0] out_line_r;
  logic       out_match_r;
  step_evt_t  out_evt_r;

  lcdt_step_unit u_step (
    .st_i     (st_r),
    .irq_en_i (irq_en_r),
    .st_o     (step_st),
    .evt_o    (step_evt)
  );

  assign cyc_sum  = {1'b0, in_cycles} + 9'd3;
  assign in_steps = lcd_en_r ? cyc_sum[8:2] : 7'd0;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_steps == 7'd0) ? ST_FINISH : ST_STEP;
        end
      end
      ST_STEP: begin
        if (steps_r == 7'd1) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = 1'b1;
    step_en  = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_STEP:   step_en  = 1'b1;
      ST_FINISH: load_out = out_free;
      default: ;
    endcase
  end

  // Datapath next values: config writes, item start, one step per cycle when no config write is pending.
  always_comb begin
    lcd_en_nxt   = lcd_en_r;
    cmp_line_nxt = cmp_line_r;
    match_ie_nxt = match_ie_r;
    irq_en_nxt   = irq_en_r;
    st_nxt       = st_r;
    match_nxt    = match_r;
    evt_nxt      = evt_r;
    steps_nxt    = steps_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LCD_ENABLE: begin
          // Turning the display off drops to hblank at line 0, dot 0.
          if (!cfg_wdata[0] && lcd_en_r) begin
            st_nxt.dot  = '0;
            st_nxt.line = '0;
            st_nxt.mode = MODE_HBLANK;
          end
          lcd_en_nxt = cfg_wdata[0];
        end
        CFG_COMPARE_LINE:  cmp_line_nxt      = cfg_wdata[7:0];
        CFG_MATCH_IRQ_EN:  match_ie_nxt      = cfg_wdata[0];
        CFG_OAM_IRQ_EN:    irq_en_nxt.oam    = cfg_wdata[0];
        CFG_HBLANK_IRQ_EN: irq_en_nxt.hblank = cfg_wdata[0];
        CFG_VBLANK_IRQ_EN: irq_en_nxt.vblank = cfg_wdata[0];
        default: ;
      endcase
    end else if (in_acc) begin
      evt_nxt   = '0;
      steps_nxt = in_steps;
      // Level compare happens once, before any step; held when display is off.
      if (lcd_en_r) begin
        match_nxt    = (st_r.line == cmp_line_r);
        evt_nxt.stat = (st_r.line == cmp_line_r) && match_ie_r;
      end
    end else if (step_en) begin
      st_nxt    = step_st;
      evt_nxt   = evt_r | step_evt;
      steps_nxt = steps_r - 7'd1;
    end
  end

  // Result register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_en_r    <= 1'b1;
      cmp_line_r  <= '0;
      match_ie_r  <= 1'b0;
      irq_en_r    <= '0;
      st_r.dot    <= '0;
      st_r.line   <= RESET_LINE;
      st_r.mode   <= MODE_VBLANK;
      match_r     <= 1'b0;
      steps_r     <= '0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      lcd_en_r    <= lcd_en_nxt;
      cmp_line_r  <= cmp_line_nxt;
      match_ie_r  <= match_ie_nxt;
      irq_en_r    <= irq_en_nxt;
      st_r        <= st_nxt;
      match_r     <= match_nxt;
      steps_r     <= steps_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Event accumulator and result payload carry no reset.
  always_ff @(posedge clk) begin
    evt_r <= evt_nxt;
    if (load_out) begin
      out_mode_r  <= st_r.mode;
      out_line_r  <= st_r.line;
      out_match_r <= match_r;
      out_evt_r   <= evt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mode       = out_mode_r;
  assign out_line       = out_line_r;
  assign out_line_match = out_match_r;
  assign out_stat_irq   = out_evt_r.stat;
  assign out_vblank_irq = out_evt_r.vbl;
  assign out_draw_line  = out_evt_r.draw;
  assign out_frame_done = out_evt_r.frame;

`ifndef SYNTHESIS
  // A new result word appears only from the finish cycle of the sequencer.
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result word posted outside finish state");

  // Stepping never runs with an exhausted step count.
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> steps_r != 7'd0)
    else $error("step state with zero steps left");

  // Line stays within the frame and dot stays on a 4-dot grid inside the line.
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.line <= FRAME_LAST)
    else $error("scanline beyond last line");

  a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.dot < LINE_DOTS && st_r.dot[1:0] == 2'd0)
    else $error("dot counter off grid or past line end");
`endif

endmodule
